### hdl/memory_test_pattern_checker_top_macros.svh
// Assertion macros for the memory test pattern checker.
// Used by the top level only; no other dependencies.
`ifndef MEMORY_TEST_PATTERN_CHECKER_TOP_MACROS_SVH
`define MEMORY_TEST_PATTERN_CHECKER_TOP_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define MTPC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define MTPC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mtpc_pkg.sv
// Shared types and constants for the memory test pattern checker.
// No dependencies.
package mtpc_pkg;

    localparam logic [31:0] SEED_BASE = 32'hABCDEF02;
    localparam logic [31:0] RAND_ADD  = 32'd13849;

    typedef enum logic [1:0] {
        KIND_RESTART = 2'd0,
        KIND_WRITE   = 2'd1,
        KIND_VERIFY  = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;

    localparam logic [1:0] REG_ACC_WIDTH    = 2'd0;
    localparam logic [1:0] REG_PATTERN_MODE = 2'd1;
    localparam logic [1:0] REG_PASS_NUMBER  = 2'd2;
    localparam logic [1:0] REG_ERROR_LIMIT  = 2'd3;

    localparam logic MODE_RANDOM = 1'b0;

    typedef struct packed {
        logic [1:0]  acc_width;
        logic        pattern_mode;
        logic [15:0] pass_number;
        logic [30:0] error_limit;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] address;
        logic [31:0] read_data;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

    typedef struct packed {
        logic [31:0] expected_pattern;
        logic        mismatch;
        logic [30:0] error_count;
        logic        limit_reached;
    } result_t;

endpackage

### hdl/mtpc_in_stage.sv
// Input register stage: captures one beat from the slave side.
// Depends on mtpc_pkg.
module mtpc_in_stage
    import mtpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] kind
    input  logic [63:0] s_tdata,   // [31:0] address, [63:32] read_data
    input  logic        advance,
    output stage_t      stage
);

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    logic  accept;

    assign s_tready = !valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (accept) begin
            valid_next          = 1'b1;
            item_next.kind      = kind_t'(s_tuser);
            item_next.address   = s_tdata[31:0];
            item_next.read_data = s_tdata[63:32];
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

### hdl/mtpc_pattern.sv
// Pattern generator: running random pattern and linear address pattern.
// Depends on mtpc_pkg.
module mtpc_pattern
    import mtpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  stage_t      stage,
    input  logic        fire,
    output logic [31:0] expected
);

    logic [31:0] running_reg, running_next;
    logic [31:0] rotated, rand_pat, lin_pat, pat, mask;
    logic [31:0] addr;
    logic        is_access;

    assign addr      = stage.item.address;
    assign is_access = (stage.item.kind == KIND_WRITE) || (stage.item.kind == KIND_VERIFY);

    always_comb begin
        case (cfg.acc_width)
            SIZE_BYTE: rotated = {running_reg[23:0], running_reg[31:24]};
            SIZE_WORD: rotated = {running_reg[15:0], running_reg[31:16]};
            default:   rotated = running_reg;
        endcase
        // x * 8197 = x + (x << 2) + (x << 13)
        if (addr[1:0] == 2'b00) begin
            rand_pat = rotated + {rotated[29:0], 2'b00} + {rotated[18:0], 13'b0} + RAND_ADD;
        end else begin
            rand_pat = rotated;
        end
    end

    always_comb begin
        case (cfg.acc_width)
            SIZE_WORD: lin_pat = addr[1] ? {addr[31:2], 1'b0, addr[0]} : {16'b0, addr[31:16]};
            SIZE_BYTE: begin
                case (addr[1:0])
                    2'd0:    lin_pat = {24'b0, addr[31:24]};
                    2'd1:    lin_pat = {16'b0, addr[31:16]};
                    2'd2:    lin_pat = {8'b0, addr[31:8]};
                    default: lin_pat = {addr[31:2], 2'b00};
                endcase
            end
            default:   lin_pat = addr;
        endcase
    end

    always_comb begin
        case (cfg.acc_width)
            SIZE_BYTE: mask = 32'h0000_00FF;
            SIZE_WORD: mask = 32'h0000_FFFF;
            default:   mask = 32'hFFFF_FFFF;
        endcase
        pat      = (cfg.pattern_mode == MODE_RANDOM) ? rand_pat : lin_pat;
        expected = is_access ? (pat & mask) : 32'b0;
    end

    always_comb begin
        running_next = running_reg;
        if (fire) begin
            if (stage.item.kind == KIND_RESTART) begin
                running_next = SEED_BASE + {16'b0, cfg.pass_number};
            end else if (is_access && cfg.pattern_mode == MODE_RANDOM) begin
                running_next = rand_pat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= SEED_BASE;
        end else begin
            running_reg <= running_next;
        end
    end

endmodule

### hdl/mtpc_checker.sv
// Read-back compare and saturating error counter.
// Depends on mtpc_pkg.
module mtpc_checker
    import mtpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  stage_t      stage,
    input  logic        fire,
    input  logic [31:0] expected,
    output result_t     result
);

    logic [30:0] errors_reg, errors_next;
    logic [31:0] rd_masked;
    logic        miss;

    always_comb begin
        case (cfg.acc_width)
            SIZE_BYTE: rd_masked = {24'b0, stage.item.read_data[7:0]};
            SIZE_WORD: rd_masked = {16'b0, stage.item.read_data[15:0]};
            default:   rd_masked = stage.item.read_data;
        endcase
        miss = (stage.item.kind == KIND_VERIFY) && (rd_masked != expected);
    end

    always_comb begin
        errors_next = errors_reg;
        if (stage.item.kind == KIND_CLEAR) begin
            errors_next = 31'b0;
        end else if (miss && (errors_reg < cfg.error_limit)) begin
            errors_next = errors_reg + 31'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            errors_reg <= 31'b0;
        end else if (fire) begin
            errors_reg <= errors_next;
        end
    end

    assign result.expected_pattern = expected;
    assign result.mismatch         = miss;
    assign result.error_count      = errors_next;
    assign result.limit_reached    = (errors_next >= cfg.error_limit);

endmodule

### hdl/memory_test_pattern_checker_top.sv
// Memory test pattern checker, top level.
// Each beat passes through two registers: the input register, then the result register.
// Throughput: one beat per cycle unless m_tready stalls the output.
// Reset (aresetn, synchronous, active low): both channels empty, pattern 0xABCDEF02,
// error count 0, registers at long access, pattern_mode 0, pass 0, limit 0x7FFFFFFF.
// Depends on mtpc_pkg, mtpc_in_stage, mtpc_pattern, mtpc_checker and the macros header.
`include "memory_test_pattern_checker_top_macros.svh"

module memory_test_pattern_checker_top
    import mtpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [30:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] kind
    input  logic [63:0] s_tdata,   // [31:0] address, [63:32] read_data
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [31:0] expected_pattern, [32] mismatch,
                                   // [63:33] error_count, [64] limit_reached, rest 0
);

    cfg_t    cfg_reg, cfg_next;
    stage_t  stage;
    logic    advance, fire;
    logic [31:0] expected;
    result_t result;
    result_t out_reg, out_next;
    logic    m_valid_reg, m_valid_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_ACC_WIDTH:    cfg_next.acc_width    = cfg_wdata[1:0];
                REG_PATTERN_MODE: cfg_next.pattern_mode = cfg_wdata[0];
                REG_PASS_NUMBER:  cfg_next.pass_number  = cfg_wdata[15:0];
                REG_ERROR_LIMIT:  cfg_next.error_limit  = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.acc_width    <= SIZE_LONG;
            cfg_reg.pattern_mode <= MODE_RANDOM;
            cfg_reg.pass_number  <= 16'd0;
            cfg_reg.error_limit  <= 31'h7FFF_FFFF;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign advance = !m_valid_reg || m_tready;
    assign fire    = stage.valid && advance;

    mtpc_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .stage    (stage)
    );

    mtpc_pattern u_pattern (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .stage    (stage),
        .fire     (fire),
        .expected (expected)
    );

    mtpc_checker u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .stage    (stage),
        .fire     (fire),
        .expected (expected),
        .result   (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (advance) begin
            m_valid_next = stage.valid;
            if (stage.valid) begin
                out_next = result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, out_reg.limit_reached, out_reg.error_count,
                       out_reg.mismatch, out_reg.expected_pattern};

    `MTPC_ASSERT_NEXT(a_ctrl_beat_zero, aclk, aresetn, fire && (stage.item.kind == KIND_RESTART || stage.item.kind == KIND_CLEAR), m_tvalid && m_tdata[31:0] == 32'b0 && !m_tdata[32], "restart/clear beat carries a pattern or mismatch")
    `MTPC_ASSERT_NEXT(a_miss_only_verify, aclk, aresetn, fire && stage.item.kind != KIND_VERIFY, !m_tdata[32], "mismatch flagged on a non-verify beat")
    `MTPC_ASSERT_NEXT(a_stalled_item_held, aclk, aresetn, stage.valid && !advance, stage.valid && $stable(stage.item), "pending beat lost while output stalled")

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for memory_test_pattern_checker_top: drives access beats and
// register writes, predicts every result beat and compares it field by field.
// Depends on mtpc_pkg and the RTL of the block only.
module tb_top;
    import mtpc_pkg::*;

    localparam logic [31:0] RAND_MULT   = 32'd8197;
    localparam logic [1:0]  SIZE_ODD    = 2'd3;
    localparam logic        MODE_LINEAR = 1'b1;
    localparam logic [30:0] LIMIT_MAX   = 31'h7FFFFFFF;
    localparam int          STUCK_LIMIT = 3000;
    localparam int          BLOCK_BEATS = 55;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [30:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser   = '0;   // [1:0] kind
    logic [63:0] s_tdata   = '0;   // [31:0] address, [63:32] read_data
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;          // [31:0] expected_pattern, [32] mismatch,
                                   // [63:33] error_count, [64] limit_reached

    cfg_t        cfg_shadow;
    logic [31:0] pattern_state;
    logic [30:0] error_tally;
    result_t     access_result_q[$];

    int send_idle_pct   = 0;
    int ready_stall_pct = 0;
    int fault_count     = 0;
    int stuck_cycles    = 0;
    int reg_writes      = 0;
    int flagged_beats   = 0;
    int kind_count[4]   = '{0, 0, 0, 0};

    memory_test_pattern_checker_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic [31:0] lane_mask();
        case (cfg_shadow.acc_width)
            SIZE_BYTE: return 32'h0000_00FF;
            SIZE_WORD: return 32'h0000_FFFF;
            default:   return 32'hFFFF_FFFF;
        endcase
    endfunction

    // pattern for an access at addr from the current running pattern, without updating it
    function automatic logic [31:0] access_pattern(input logic [31:0] addr);
        logic [31:0] p;
        p = pattern_state;
        if (cfg_shadow.pattern_mode == MODE_RANDOM) begin
            if (cfg_shadow.acc_width == SIZE_BYTE)
                p = {p[23:0], p[31:24]};
            else if (cfg_shadow.acc_width == SIZE_WORD)
                p = {p[15:0], p[31:16]};
            if (addr[1:0] == 2'b00)
                p = p * RAND_MULT + RAND_ADD;
        end else begin
            case (cfg_shadow.acc_width)
                SIZE_WORD: p = addr[1] ? {addr[31:2], 1'b0, addr[0]} : addr >> 16;
                SIZE_BYTE: begin
                    case (addr[1:0])
                        2'd0:    p = addr >> 24;
                        2'd1:    p = addr >> 16;
                        2'd2:    p = addr >> 8;
                        default: p = {addr[31:2], 2'b00};
                    endcase
                end
                default: p = addr;
            endcase
        end
        return p;
    endfunction

    // read data that matches in the compared lanes, noise above them
    function automatic logic [31:0] echo_data(input logic [31:0] addr, input logic [31:0] noise);
        return (noise & ~lane_mask()) | (access_pattern(addr) & lane_mask());
    endfunction

    function automatic void record_access(input kind_t kind, input logic [31:0] addr,
                                          input logic [31:0] rdata);
        result_t     r;
        logic [31:0] pat;
        r = '0;
        case (kind)
            KIND_RESTART: pattern_state = SEED_BASE + {16'd0, cfg_shadow.pass_number};
            KIND_CLEAR:   error_tally = '0;
            default: begin
                pat = access_pattern(addr);
                if (cfg_shadow.pattern_mode == MODE_RANDOM)
                    pattern_state = pat;
                r.expected_pattern = pat & lane_mask();
                if (kind == KIND_VERIFY && (rdata & lane_mask()) != r.expected_pattern) begin
                    r.mismatch = 1'b1;
                    flagged_beats++;
                    if (error_tally < cfg_shadow.error_limit)
                        error_tally = error_tally + 31'd1;
                end
            end
        endcase
        r.error_count   = error_tally;
        r.limit_reached = (error_tally >= cfg_shadow.error_limit);
        kind_count[kind]++;
        access_result_q.push_back(r);
    endfunction

    task automatic send_access(input kind_t kind, input logic [31:0] addr,
                               input logic [31:0] rdata);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {rdata, addr};
        do @(posedge aclk); while (!s_tready);
        record_access(kind, addr, rdata);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (access_result_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_ACC_WIDTH:    cfg_shadow.acc_width    = value[1:0];
            REG_PATTERN_MODE: cfg_shadow.pattern_mode = value[0];
            REG_PASS_NUMBER:  cfg_shadow.pass_number  = value[15:0];
            default:          cfg_shadow.error_limit  = value;
        endcase
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [1:0] size, input logic mode,
                              input logic [15:0] pass, input logic [30:0] limit);
        drain_results();
        write_reg(REG_ACC_WIDTH, {29'd0, size});
        write_reg(REG_PATTERN_MODE, {30'd0, mode});
        write_reg(REG_PASS_NUMBER, {15'd0, pass});
        write_reg(REG_ERROR_LIMIT, limit);
    endtask

    // reset registers: long accesses, chained pattern, widest limit
    task automatic test_reset_state();
        send_access(KIND_WRITE, 32'h0000_0000, 32'h0000_0000);
        send_access(KIND_VERIFY, 32'h0000_0001, 32'h0000_0000);
        send_access(KIND_VERIFY, 32'hFFFF_FFFF, echo_data(32'hFFFF_FFFF, 32'h0));
        send_access(KIND_CLEAR, 32'h0000_0000, 32'hFFFF_FFFF);
        send_access(KIND_RESTART, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_limit_saturation();
        set_config(SIZE_BYTE, MODE_RANDOM, 16'hFFFF, 31'd1);
        send_access(KIND_RESTART, 32'h0000_0000, 32'h0000_0000);
        send_access(KIND_VERIFY, 32'h0000_0000, ~echo_data(32'h0000_0000, 32'h0));
        send_access(KIND_VERIFY, 32'h0000_0002, ~echo_data(32'h0000_0002, 32'h0));
        send_access(KIND_WRITE, 32'h0000_0003, 32'hFFFF_FFFF);
    endtask

    task automatic test_linear_mode();
        logic [31:0] base;
        base = 32'hA5C3_0F10;
        set_config(SIZE_WORD, MODE_LINEAR, 16'h0000, 31'd0);
        send_access(KIND_VERIFY, 32'h1234_5678, echo_data(32'h1234_5678, 32'hFFFF_FFFF));
        send_access(KIND_VERIFY, 32'hFFFF_FFFE, 32'h0000_0000);
        send_access(KIND_CLEAR, 32'hFFFF_FFFF, 32'h0000_0000);
        set_config(SIZE_BYTE, MODE_LINEAR, 16'h0000, 31'd0);
        for (int lane = 0; lane < 4; lane++)
            send_access(KIND_VERIFY, base | 32'(lane), $urandom());
    endtask

    // access size three behaves as a long access
    task automatic test_odd_size();
        set_config(SIZE_ODD, MODE_RANDOM, 16'h0000, LIMIT_MAX);
        send_access(KIND_WRITE, 32'h0000_0000, 32'h0000_0000);
        send_access(KIND_VERIFY, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
        set_config(SIZE_ODD, MODE_LINEAR, 16'h0000, LIMIT_MAX);
        send_access(KIND_VERIFY, 32'hFFFF_FFFF, echo_data(32'hFFFF_FFFF, 32'h0));
        set_config(SIZE_LONG, MODE_RANDOM, 16'h0000, LIMIT_MAX);
        send_access(KIND_RESTART, 32'h0000_0000, 32'h0000_0000);
    endtask

    task automatic random_access();
        kind_t       kind;
        logic [31:0] addr;
        logic [31:0] rdata;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 5)
            kind = KIND_RESTART;
        else if (pick < 13)
            kind = KIND_CLEAR;
        else if (pick < 45)
            kind = KIND_WRITE;
        else
            kind = KIND_VERIFY;
        addr = $urandom();
        if ($urandom_range(3) == 0)
            addr[1:0] = 2'b00;
        rdata = $urandom();
        pick  = $urandom_range(99);
        if (kind == KIND_VERIFY && pick < 65)
            rdata = echo_data(addr, rdata);
        else if (kind == KIND_VERIFY && pick < 80)
            rdata = echo_data(addr, rdata) ^ (32'd1 << $urandom_range(31));
        send_access(kind, addr, rdata);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        logic [30:0] limit;
        int          pick;
        send_idle_pct   = idle_pct;
        ready_stall_pct = stall_pct;
        for (int blk = 0; blk < 5; blk++) begin
            pick = $urandom_range(9);
            if (pick < 6)
                limit = 31'($urandom_range(12, 1));
            else if (pick < 8)
                limit = 31'($urandom());
            else if (pick < 9)
                limit = LIMIT_MAX;
            else
                limit = 31'd0;
            pick = $urandom_range(3);
            set_config(2'($urandom_range(3)),
                       ($urandom_range(9) < 3) ? MODE_LINEAR : MODE_RANDOM,
                       (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom()),
                       limit);
            for (int n = 0; n < BLOCK_BEATS; n++) begin
                if ($urandom_range(99) < 3)
                    drain_results();
                random_access();
            end
        end
        drain_results();
        send_idle_pct   = 0;
        ready_stall_pct = 0;
    endtask

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= ready_stall_pct);

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            fault_count++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (access_result_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none got %h",
                         $time, m_tdata);
                fault_count++;
            end else begin
                want = access_result_q.pop_front();
                check_field("expected_pattern", want.expected_pattern, m_tdata[31:0]);
                check_field("mismatch", {31'd0, want.mismatch}, {31'd0, m_tdata[32]});
                check_field("error_count", {1'b0, want.error_count}, {1'b0, m_tdata[63:33]});
                check_field("limit_reached", {31'd0, want.limit_reached},
                            {31'd0, m_tdata[64]});
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                     $time, STUCK_LIMIT, access_result_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        cfg_shadow    = '{acc_width: SIZE_LONG, pattern_mode: MODE_RANDOM,
                          pass_number: 16'h0000, error_limit: LIMIT_MAX};
        pattern_state = SEED_BASE;
        error_tally   = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_limit_saturation();
        test_linear_mode();
        test_odd_size();
        test_random_traffic(0, 0);
        test_random_traffic(81, 0);
        test_random_traffic(0, 81);
        test_random_traffic(21, 21);
        drain_results();

        if (access_result_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, access_result_q.size());
            fault_count++;
        end
        $display("Checked %0d writes and %0d verifies (%0d flagged), %0d restarts, %0d clears",
                 kind_count[KIND_WRITE], kind_count[KIND_VERIFY], flagged_beats,
                 kind_count[KIND_RESTART], kind_count[KIND_CLEAR]);
        $display("across %0d register writes and four idle/stall phases", reg_writes);
        if (fault_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/mtpc_pkg.sv
hdl/mtpc_in_stage.sv
hdl/mtpc_pattern.sv
hdl/mtpc_checker.sv
hdl/memory_test_pattern_checker_top.sv
verif/tb_top.sv
